### rtl/core/cosim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity package
// Shared widths, control structs and state encodings for the cosine
// similarity unit and its submodules.
// ----------------------------------------------------------------------------
package cosim_pkg;

	localparam int COUNT_W  = 16;
	localparam int SUM_W    = 40;
	localparam int LIMB_W   = 20;
	localparam int PROD_W   = 2 * LIMB_W;
	localparam int ACC_W    = 120;
	localparam int OFF_W    = 3;
	localparam int FRAC_W   = 16;
	localparam int SIM_W    = FRAC_W + 1;
	localparam int BIT_W    = 5;
	localparam int STEP_W   = 3;

	localparam logic [BIT_W-1:0]  TOP_BIT        = BIT_W'(FRAC_W);
	localparam logic [STEP_W-1:0] LAST_STEP_WIDE = 3'd3;
	localparam logic [STEP_W-1:0] LAST_STEP_SQR  = 3'd0;
	localparam logic [STEP_W-1:0] LAST_STEP_LHS  = 3'd7;

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_DRAIN,
		ST_LATCH,
		ST_ISSUE,
		ST_FLUSH,
		ST_STORE,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_NORM,
		PH_DOT,
		PH_SQUARE,
		PH_LHS
	} phase_t;

	typedef struct packed {
		logic             issue;
		logic             clear;
		logic [OFF_W-1:0] offset;
	} mac_ctrl_t;

	typedef struct packed {
		logic [SUM_W-1:0] dot;
		logic [SUM_W-1:0] square_a;
		logic [SUM_W-1:0] square_b;
		logic             overflow;
	} sums_t;

	typedef struct packed {
		logic [SIM_W-1:0] similarity;
		logic             zero_norm;
		logic             too_many;
	} result_t;

endpackage

### rtl/core/cosim_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity accumulator
// Registers the three element products of each accepted pair and adds them
// into the dot product and the two sums of squares on the next cycle.
// ----------------------------------------------------------------------------
module cosim_accum
	import cosim_pkg::*;
#(
	parameter int MAX_ELEMENTS = 256,
	parameter int COUNT_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [COUNT_W-1:0] count_a,
	input  logic [COUNT_W-1:0] count_b,
	input  logic               clear,
	output sums_t              sums
);

	localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
	localparam int MASK_BITS = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;
	localparam logic [COUNT_W:0] MASK_FULL =
		((COUNT_W+1)'(1) << MASK_BITS) - (COUNT_W+1)'(1);
	localparam logic [COUNT_W-1:0] COUNT_MASK = MASK_FULL[COUNT_W-1:0];

	logic [COUNT_W-1:0]   a_m;
	logic [COUNT_W-1:0]   b_m;
	logic                 room;
	logic [CNT_W-1:0]     count_q;
	logic                 overflow_q;
	logic                 add_s1;
	logic [2*COUNT_W-1:0] prod_ab_s1;
	logic [2*COUNT_W-1:0] prod_aa_s1;
	logic [2*COUNT_W-1:0] prod_bb_s1;
	logic [SUM_W-1:0]     dot_q;
	logic [SUM_W-1:0]     square_a_q;
	logic [SUM_W-1:0]     square_b_q;

	assign a_m  = count_a & COUNT_MASK;
	assign b_m  = count_b & COUNT_MASK;
	assign room = count_q < CNT_W'(MAX_ELEMENTS);

	always_ff @(posedge clk) begin
		prod_ab_s1 <= a_m * b_m;
		prod_aa_s1 <= a_m * a_m;
		prod_bb_s1 <= b_m * b_m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
			add_s1     <= 1'b0;
			dot_q      <= '0;
			square_a_q <= '0;
			square_b_q <= '0;
		end else if (clear) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
			add_s1     <= 1'b0;
			dot_q      <= '0;
			square_a_q <= '0;
			square_b_q <= '0;
		end else begin
			add_s1 <= accept && room;
			if (accept) begin
				if (room) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (add_s1) begin
				dot_q      <= dot_q + SUM_W'(prod_ab_s1);
				square_a_q <= square_a_q + SUM_W'(prod_aa_s1);
				square_b_q <= square_b_q + SUM_W'(prod_bb_s1);
			end
		end
	end

	assign sums.dot      = dot_q;
	assign sums.square_a = square_a_q;
	assign sums.square_b = square_b_q;
	assign sums.overflow = overflow_q;

endmodule

### rtl/core/cosim_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity multiply-accumulate unit
// One shared limb multiplier with a registered product, added into a wide
// accumulator at a limb offset on the following cycle.
// ----------------------------------------------------------------------------
module cosim_mac
	import cosim_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  mac_ctrl_t         ctrl,
	input  logic [LIMB_W-1:0] op_a,
	input  logic [LIMB_W-1:0] op_b,
	output logic [ACC_W-1:0]  acc
);

	logic              vld_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [OFF_W-1:0]  off_s1;
	logic [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctrl.issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		off_s1  <= ctrl.offset;
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + (ACC_W'(prod_s1) << (LIMB_W * off_s1));
		end
	end

	assign acc = acc_q;

endmodule

### rtl/core/cosim_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity sequencer
// Forms the norm product and the scaled squared dot product on the shared
// multiplier, then finds the similarity one bit at a time by comparing
// candidate squares times the norm product against the squared dot product.
// ----------------------------------------------------------------------------
module cosim_seq
	import cosim_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              last_accept,
	input  sums_t             sums,
	input  logic              res_free,
	input  logic [ACC_W-1:0]  mac_acc,
	output mac_ctrl_t         mac_ctrl,
	output logic [LIMB_W-1:0] mac_a,
	output logic [LIMB_W-1:0] mac_b,
	output logic              accepting,
	output logic              accum_clear,
	output logic              result_load,
	output result_t           result
);

	state_t                 state_q;
	state_t                 state_d;
	phase_t                 phase_q;
	logic [STEP_W-1:0]      step_q;
	logic [BIT_W-1:0]       bit_q;
	logic [SIM_W-1:0]       r_q;
	logic                   zero_q;
	logic [2*SUM_W-1:0]     prod_q;
	logic [2*SUM_W-1:0]     d2_q;
	logic [SUM_W-1:0]       sq_q;

	logic                   zero_norm;
	logic                   last_step;
	logic [SIM_W-1:0]       cand;
	logic [ACC_W-1:0]       rhs;
	logic [SIM_W-1:0]       r_next;
	logic                   finish;
	logic [SUM_W-1:0]       x_word;
	logic [2*SUM_W-1:0]     y_word;
	logic [1:0][LIMB_W-1:0] x_limbs;
	logic [3:0][LIMB_W-1:0] y_limbs;
	logic                   xi;
	logic [1:0]             yj;

	assign zero_norm = (sums.square_a == '0) || (sums.square_b == '0);
	assign cand      = r_q | (SIM_W'(1) << bit_q);
	assign rhs       = ACC_W'({d2_q, {(2*FRAC_W){1'b0}}});
	assign r_next    = (mac_acc <= rhs) ? cand : r_q;
	assign finish    = (bit_q == '0) || r_next[SIM_W-1];
	assign xi        = step_q[0];
	assign yj        = step_q[2:1];

	always_comb begin
		unique case (phase_q)
			PH_NORM: last_step = (step_q == LAST_STEP_WIDE);
			PH_DOT: last_step = (step_q == LAST_STEP_WIDE);
			PH_SQUARE: last_step = (step_q == LAST_STEP_SQR);
			PH_LHS: last_step = (step_q == LAST_STEP_LHS);
			default: last_step = 1'b1;
		endcase
	end

	always_comb begin
		unique case (phase_q)
			PH_NORM: begin
				x_word = sums.square_a;
				y_word = (2*SUM_W)'(sums.square_b);
			end
			PH_DOT: begin
				x_word = sums.dot;
				y_word = (2*SUM_W)'(sums.dot);
			end
			PH_SQUARE: begin
				x_word = SUM_W'(cand);
				y_word = (2*SUM_W)'(cand);
			end
			default: begin
				x_word = sq_q;
				y_word = prod_q;
			end
		endcase
		x_limbs = x_word;
		y_limbs = y_word;
		mac_a   = x_limbs[xi];
		mac_b   = y_limbs[yj];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_ACCUM: begin
				if (last_accept) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_LATCH;
			ST_LATCH: begin
				if (zero_norm) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (last_step) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: state_d = ST_STORE;
			ST_STORE: begin
				if (phase_q == PH_LHS && finish) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_ISSUE;
				end
			end
			ST_DONE: begin
				if (res_free) begin
					state_d = ST_ACCUM;
				end
			end
			default: state_d = ST_ACCUM;
		endcase
	end

	always_comb begin
		accepting       = (state_q == ST_ACCUM);
		mac_ctrl.issue  = (state_q == ST_ISSUE);
		mac_ctrl.clear  = (state_q == ST_ISSUE) && (step_q == '0);
		mac_ctrl.offset = OFF_W'(xi) + OFF_W'(yj);
		result_load     = (state_q == ST_DONE) && res_free;
		accum_clear     = result_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			phase_q <= PH_NORM;
			step_q  <= '0;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_LATCH: begin
					phase_q <= PH_NORM;
					step_q  <= '0;
				end
				ST_ISSUE: begin
					step_q <= last_step ? '0 : step_q + STEP_W'(1);
				end
				ST_STORE: begin
					unique case (phase_q)
						PH_NORM: phase_q <= PH_DOT;
						PH_DOT: begin
							phase_q <= PH_SQUARE;
							bit_q   <= TOP_BIT;
						end
						PH_SQUARE: phase_q <= PH_LHS;
						default: begin
							phase_q <= PH_SQUARE;
							bit_q   <= bit_q - BIT_W'(1);
						end
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LATCH) begin
			r_q    <= '0;
			zero_q <= zero_norm;
		end
		if (state_q == ST_STORE) begin
			unique case (phase_q)
				PH_NORM: prod_q <= mac_acc[2*SUM_W-1:0];
				PH_DOT: d2_q <= mac_acc[2*SUM_W-1:0];
				PH_SQUARE: sq_q <= mac_acc[SUM_W-1:0];
				default: r_q <= r_next;
			endcase
		end
	end

	assign result.similarity = r_q;
	assign result.zero_norm  = zero_q;
	assign result.too_many   = sums.overflow;

endmodule

### rtl/core/cosine_similarity_unit.sv
`timescale 1ns / 1ps
// Throughput: one element pair per cycle while accumulating.
// Sequence: after a last pair is accepted, the two 80-bit products are formed
// on the shared 20x20 multiplier, then up to 17 candidate bits are tried,
// stopping early when the result reaches 1.0; a zero norm skips all of this.
// No pair is accepted during that run.
// Reset: asynchronous, clears the sums, the counters and the output valid flag; the output data register is not reset.
// ----------------------------------------------------------------------------
// Cosine similarity unit
// Accumulates dot product and sums of squares of two count vectors and
// delivers their cosine similarity as an unsigned Q1.16 fraction.
// ----------------------------------------------------------------------------
module cosine_similarity_unit
	import cosim_pkg::*;
#(
	parameter int MAX_ELEMENTS = 256,
	parameter int COUNT_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               count_valid,
	output logic               count_stall,
	input  logic [COUNT_W-1:0] count_a,
	input  logic [COUNT_W-1:0] count_b,
	input  logic               last_element,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [SIM_W-1:0]   similarity,
	output logic               zero_norm,
	output logic               too_many
);

	logic              accept;
	logic              accepting;
	logic              accum_clear;
	logic              result_load;
	logic              res_free;
	sums_t             sums;
	mac_ctrl_t         mac_ctrl;
	logic [LIMB_W-1:0] mac_a;
	logic [LIMB_W-1:0] mac_b;
	logic [ACC_W-1:0]  mac_acc;
	result_t           result;
	logic              result_valid_q;
	result_t           result_q;

	assign count_stall = !accepting;
	assign accept      = count_valid && accepting;
	assign res_free    = !result_valid_q || !result_stall;

	cosim_accum #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.COUNT_BITS  (COUNT_BITS)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.count_a(count_a),
		.count_b(count_b),
		.clear  (accum_clear),
		.sums   (sums)
	);

	cosim_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (mac_ctrl),
		.op_a  (mac_a),
		.op_b  (mac_b),
		.acc   (mac_acc)
	);

	cosim_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.last_accept(accept && last_element),
		.sums       (sums),
		.res_free   (res_free),
		.mac_acc    (mac_acc),
		.mac_ctrl   (mac_ctrl),
		.mac_a      (mac_a),
		.mac_b      (mac_b),
		.accepting  (accepting),
		.accum_clear(accum_clear),
		.result_load(result_load),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (result_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			result_q <= result;
		end
	end

	assign result_valid = result_valid_q;
	assign similarity   = result_q.similarity;
	assign zero_norm    = result_q.zero_norm;
	assign too_many     = result_q.too_many;

endmodule
